@@ src/pst_pkg.sv @@
// pst_pkg: shared types, codes and sizes for the priority thread scheduler
// no dependencies; used by every file of the block
package pst_pkg;

    // default number of thread slots (the main thread takes one more entry)
    localparam int SLOTS_DEFAULT = 4;

    // payload widths
    localparam int ACTION_W = 3;
    localparam int PRIO_W   = 2;
    localparam int SLOT_W   = 3;
    localparam int STATE_W  = 2;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_CREATE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_YIELD  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_EXIT   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SETPRI = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_START  = 3'd4;

    // slot state codes
    localparam logic [STATE_W-1:0] ST_FREE     = 2'd0;
    localparam logic [STATE_W-1:0] ST_RUNNABLE = 2'd1;
    localparam logic [STATE_W-1:0] ST_RUNNING  = 2'd2;

    // priority codes
    localparam logic [PRIO_W-1:0] PRIO_LOW  = 2'd0;
    localparam logic [PRIO_W-1:0] PRIO_HIGH = 2'd2;

    // one slot table entry
    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    // flags gathered by the table scan
    typedef struct packed {
        logic found;
        logic live;
    } scan_flags_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CUR_RD,
        S_CUR_WB,
        S_SCAN,
        S_SCAN_END,
        S_COMMIT,
        S_FIN_RD,
        S_FIN
    } fsm_t;

    // priority code three saturates to high
    function automatic logic [PRIO_W-1:0] sat_prio(input logic [PRIO_W-1:0] p);
        logic [PRIO_W-1:0] r;
        r = (p > PRIO_HIGH) ? PRIO_HIGH : p;
        return r;
    endfunction

endpackage

@@ src/pst_if.sv @@
// pst_req_if / pst_rsp_if: valid-ready channels of the scheduler
// depends on pst_pkg for payload widths
interface pst_req_if;
    logic                          valid;
    logic                          ready;
    logic [pst_pkg::ACTION_W-1:0]  action;
    logic [pst_pkg::PRIO_W-1:0]    priority_req;

    modport source (output valid, action, priority_req, input ready);
    modport sink   (input valid, action, priority_req, output ready);
endinterface

interface pst_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic [pst_pkg::SLOT_W-1:0]  slot;
    logic                        switched;
    logic [pst_pkg::PRIO_W-1:0]  prev_priority;
    logic [pst_pkg::PRIO_W-1:0]  current_priority;
    logic                        all_exited;

    modport source (output valid, ok, slot, switched, prev_priority, current_priority,
                    all_exited, input ready);
    modport sink   (input valid, ok, slot, switched, prev_priority, current_priority,
                    all_exited, output ready);
endinterface

@@ src/pst_table.sv @@
// pst_table: slot table memory, one write port and one registered read port
// depends on pst_pkg; entries never written read as free at low priority
module pst_table #(
    parameter int SLOTS = pst_pkg::SLOTS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               rd_en,
    input  logic [$clog2(SLOTS+1)-1:0]         rd_addr,
    output pst_pkg::entry_t                    rd_data,
    input  logic                               wr_en,
    input  logic [$clog2(SLOTS+1)-1:0]         wr_addr,
    input  pst_pkg::entry_t                    wr_data
);

    localparam int DEPTH = SLOTS + 1;

    pst_pkg::entry_t   mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    pst_pkg::entry_t   rdata_reg;
    logic              rvalid_reg;

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // per-entry written flags and the flag of the read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten entries read as the reset value
    always_comb
    begin
        if (rvalid_reg)
        begin
            rd_data = rdata_reg;
        end
        else
        begin
            rd_data.state = pst_pkg::ST_FREE;
            rd_data.prio  = pst_pkg::PRIO_LOW;
        end
    end

endmodule

@@ src/pst_scan.sv @@
// pst_scan: accumulates the pick over the table one entry per cycle
// depends on pst_pkg; first free slot for create, last best runnable otherwise
module pst_scan #(
    parameter int SLOTS = pst_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         en,
    input  logic                         create_mode,
    input  logic [$clog2(SLOTS+1)-1:0]   idx,
    input  pst_pkg::entry_t              entry,
    output pst_pkg::scan_flags_t         flags,
    output logic [$clog2(SLOTS+1)-1:0]   pick,
    output logic [pst_pkg::PRIO_W-1:0]   best
);

    localparam int AW = $clog2(SLOTS + 1);

    pst_pkg::scan_flags_t        flags_reg, flags_next;
    logic [AW-1:0]               pick_reg, pick_next;
    logic [pst_pkg::PRIO_W-1:0]  best_reg, best_next;
    logic                        is_free;

    // fold one entry into the running result
    always_comb
    begin
        flags_next = flags_reg;
        pick_next  = pick_reg;
        best_next  = best_reg;
        is_free    = (entry.state == pst_pkg::ST_FREE);
        if (clear)
        begin
            flags_next = '0;
            pick_next  = '0;
            best_next  = pst_pkg::PRIO_LOW;
        end
        else if (en)
        begin
            if (!is_free)
            begin
                flags_next.live = 1'b1;
            end
            if (create_mode)
            begin
                if (is_free && !flags_reg.found)
                begin
                    flags_next.found = 1'b1;
                    pick_next        = idx;
                end
            end
            else if (entry.state == pst_pkg::ST_RUNNABLE && entry.prio >= best_reg)
            begin
                flags_next.found = 1'b1;
                pick_next        = idx;
                best_next        = entry.prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            pick_reg  <= '0;
            best_reg  <= pst_pkg::PRIO_LOW;
        end
        else
        begin
            flags_reg <= flags_next;
            pick_reg  <= pick_next;
            best_reg  <= best_next;
        end
    end

    assign flags = flags_reg;
    assign pick  = pick_reg;
    assign best  = best_reg;

endmodule

@@ src/pst_ctrl.sv @@
// pst_ctrl: action sequencer, read-modify-write of the slot table, result register
// depends on pst_pkg, pst_req_if and pst_rsp_if; drives pst_table and pst_scan
module pst_ctrl #(
    parameter int SLOTS = pst_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    pst_req_if.sink                      req,
    pst_rsp_if.source                    rsp,
    output logic                         rd_en,
    output logic [$clog2(SLOTS+1)-1:0]   rd_addr,
    input  pst_pkg::entry_t              rd_data,
    output logic                         wr_en,
    output logic [$clog2(SLOTS+1)-1:0]   wr_addr,
    output pst_pkg::entry_t              wr_data,
    output logic                         scan_clear,
    output logic                         scan_en,
    output logic                         scan_create,
    output logic [$clog2(SLOTS+1)-1:0]   scan_idx,
    input  pst_pkg::scan_flags_t         scan_flags,
    input  logic [$clog2(SLOTS+1)-1:0]   scan_pick,
    input  logic [pst_pkg::PRIO_W-1:0]   scan_best
);

    localparam int AW = $clog2(SLOTS + 1);
    localparam logic [AW-1:0] MAIN_SLOT = AW'(SLOTS);
    localparam logic [AW-1:0] LAST_IDX  = AW'(SLOTS - 1);

    pst_pkg::fsm_t                 state_reg, state_next;
    logic [pst_pkg::ACTION_W-1:0]  act_reg, act_next;
    logic [pst_pkg::PRIO_W-1:0]    prio_reg, prio_next;
    logic [AW-1:0]                 cur_reg, cur_next;
    logic                          pending_reg, pending_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic                          rd_scan_reg;
    logic [AW-1:0]                 rd_idx_reg;
    // working result of the transaction in progress
    logic                          ok_reg, ok_next;
    logic                          sw_reg, sw_next;
    logic [pst_pkg::PRIO_W-1:0]    oldp_reg, oldp_next;
    logic                          done_reg, done_next;
    logic [AW-1:0]                 made_reg, made_next;
    // result register towards the sink
    logic                          out_valid_reg, out_valid_next;
    logic                          out_ok_reg;
    logic [pst_pkg::SLOT_W-1:0]    out_slot_reg;
    logic                          out_sw_reg;
    logic [pst_pkg::PRIO_W-1:0]    out_oldp_reg;
    logic [pst_pkg::PRIO_W-1:0]    out_curp_reg;
    logic                          out_done_reg;
    logic                          accept;
    logic                          out_load;
    logic                          yield_like;

    assign accept     = req.valid && req.ready;
    assign out_load   = (state_reg == pst_pkg::S_FIN) && (!out_valid_reg || rsp.ready);
    assign yield_like = (act_reg == pst_pkg::ACT_YIELD) || (act_reg == pst_pkg::ACT_START)
                        || (act_reg == pst_pkg::ACT_EXIT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pst_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (req.action)
                        pst_pkg::ACT_CREATE: state_next = pst_pkg::S_SCAN;
                        pst_pkg::ACT_YIELD:  state_next = pst_pkg::S_CUR_RD;
                        pst_pkg::ACT_EXIT:   state_next = pst_pkg::S_CUR_RD;
                        pst_pkg::ACT_SETPRI: state_next = pst_pkg::S_CUR_RD;
                        pst_pkg::ACT_START:
                            state_next = pending_reg ? pst_pkg::S_CUR_RD : pst_pkg::S_FIN_RD;
                        default:             state_next = pst_pkg::S_FIN_RD;
                    endcase
                end
            end
            pst_pkg::S_CUR_RD:   state_next = pst_pkg::S_CUR_WB;
            pst_pkg::S_CUR_WB:
                state_next = (act_reg == pst_pkg::ACT_SETPRI) ? pst_pkg::S_FIN_RD
                                                              : pst_pkg::S_SCAN;
            pst_pkg::S_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = pst_pkg::S_SCAN_END;
                end
            end
            pst_pkg::S_SCAN_END: state_next = pst_pkg::S_COMMIT;
            pst_pkg::S_COMMIT:   state_next = pst_pkg::S_FIN_RD;
            pst_pkg::S_FIN_RD:   state_next = pst_pkg::S_FIN;
            pst_pkg::S_FIN:
            begin
                if (out_load)
                begin
                    state_next = pst_pkg::S_IDLE;
                end
            end
            default:             state_next = pst_pkg::S_IDLE;
        endcase
    end

    // table accesses and working registers
    always_comb
    begin
        act_next     = act_reg;
        prio_next    = prio_reg;
        cur_next     = cur_reg;
        pending_next = pending_reg;
        idx_next     = idx_reg;
        ok_next      = ok_reg;
        sw_next      = sw_reg;
        oldp_next    = oldp_reg;
        done_next    = done_reg;
        made_next    = made_reg;
        rd_en        = 1'b0;
        rd_addr      = cur_reg;
        wr_en        = 1'b0;
        wr_addr      = cur_reg;
        wr_data      = rd_data;
        case (state_reg)
            pst_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    act_next  = req.action;
                    prio_next = pst_pkg::sat_prio(req.priority_req);
                    idx_next  = '0;
                    ok_next   = 1'b0;
                    sw_next   = 1'b0;
                    oldp_next = pst_pkg::PRIO_LOW;
                    done_next = 1'b0;
                    if (req.action == pst_pkg::ACT_START && pending_reg)
                    begin
                        pending_next = 1'b0;
                        ok_next      = 1'b1;
                    end
                end
            end
            pst_pkg::S_CUR_RD:
            begin
                rd_en = 1'b1;
            end
            pst_pkg::S_CUR_WB:
            begin
                case (act_reg)
                    pst_pkg::ACT_SETPRI:
                    begin
                        wr_en        = 1'b1;
                        wr_data.prio = prio_reg;
                        oldp_next    = rd_data.prio;
                    end
                    pst_pkg::ACT_EXIT:
                    begin
                        wr_en         = 1'b1;
                        wr_data.state = pst_pkg::ST_FREE;
                    end
                    default:
                    begin
                        // running thread goes back to runnable before the pick
                        if (rd_data.state == pst_pkg::ST_RUNNING)
                        begin
                            wr_en         = 1'b1;
                            wr_data.state = pst_pkg::ST_RUNNABLE;
                        end
                    end
                endcase
            end
            pst_pkg::S_SCAN:
            begin
                rd_en    = 1'b1;
                rd_addr  = idx_reg;
                idx_next = idx_reg + 1'b1;
            end
            pst_pkg::S_COMMIT:
            begin
                if (act_reg == pst_pkg::ACT_CREATE)
                begin
                    if (scan_flags.found)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = scan_pick;
                        wr_data.state = pst_pkg::ST_RUNNABLE;
                        wr_data.prio  = prio_reg;
                        ok_next       = 1'b1;
                        made_next     = scan_pick;
                    end
                end
                else if (act_reg == pst_pkg::ACT_EXIT && !scan_flags.live)
                begin
                    done_next = 1'b1;
                end
                else if (yield_like && scan_flags.found)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = scan_pick;
                    wr_data.state = pst_pkg::ST_RUNNING;
                    wr_data.prio  = scan_best;
                    if (scan_pick != cur_reg)
                    begin
                        cur_next = scan_pick;
                        sw_next  = 1'b1;
                    end
                end
            end
            pst_pkg::S_FIN_RD:
            begin
                rd_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // scan unit control: data of an issued scan read arrives in the next cycle
    assign scan_clear  = !(state_reg == pst_pkg::S_SCAN || state_reg == pst_pkg::S_SCAN_END);
    assign scan_en     = rd_scan_reg;
    assign scan_idx    = rd_idx_reg;
    assign scan_create = (act_reg == pst_pkg::ACT_CREATE);

    // result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pst_pkg::S_IDLE;
            cur_reg       <= MAIN_SLOT;
            pending_reg   <= 1'b1;
            idx_reg       <= '0;
            rd_scan_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            pending_reg   <= pending_next;
            idx_reg       <= idx_next;
            rd_scan_reg   <= (state_reg == pst_pkg::S_SCAN);
            rd_idx_reg    <= idx_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result payload registers
    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        prio_reg <= prio_next;
        ok_reg   <= ok_next;
        sw_reg   <= sw_next;
        oldp_reg <= oldp_next;
        done_reg <= done_next;
        made_reg <= made_next;
        if (out_load)
        begin
            out_ok_reg   <= ok_reg;
            out_slot_reg <= (act_reg == pst_pkg::ACT_CREATE && ok_reg)
                            ? pst_pkg::SLOT_W'(made_reg) : pst_pkg::SLOT_W'(cur_reg);
            out_sw_reg   <= sw_reg;
            out_oldp_reg <= oldp_reg;
            out_curp_reg <= rd_data.prio;
            out_done_reg <= done_reg;
        end
    end

    assign req.ready            = (state_reg == pst_pkg::S_IDLE);
    assign rsp.valid            = out_valid_reg;
    assign rsp.ok               = out_ok_reg;
    assign rsp.slot             = out_slot_reg;
    assign rsp.switched         = out_sw_reg;
    assign rsp.prev_priority    = out_oldp_reg;
    assign rsp.current_priority = out_curp_reg;
    assign rsp.all_exited       = out_done_reg;

endmodule

@@ src/priority_thread_scheduler_unit.sv @@
// priority_thread_scheduler_unit: top level of the static-priority thread scheduler
// depends on pst_pkg, pst_if, pst_table, pst_scan and pst_ctrl
//
//   channel | dir | handshake   | payload
//   --------+-----+-------------+----------------------------------------------
//   req     | in  | valid/ready | action, priority_req
//   rsp     | out | valid/ready | ok, slot, switched, prev_priority,
//           |     |             | current_priority, all_exited
//
// one transaction at a time, set by the single read port of the slot table:
// set priority, unused actions and a repeated start skip the scan; create, yield, exit
// and a first start scan the table (one table entry is read per cycle during the scan).
// reset is asynchronous; the table needs no clearing pass, written flags cover it.
// a new request is taken while the previous result waits in the output register;
// a stalled sink holds the block only when the next result is ready to load.
module priority_thread_scheduler_unit #(
    parameter int SLOTS = pst_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    pst_req_if.sink     req,
    pst_rsp_if.source   rsp
);

    localparam int AW = $clog2(SLOTS + 1);

    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    pst_pkg::entry_t             rd_data;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    pst_pkg::entry_t             wr_data;
    logic                        scan_clear;
    logic                        scan_en;
    logic                        scan_create;
    logic [AW-1:0]               scan_idx;
    pst_pkg::scan_flags_t        scan_flags;
    logic [AW-1:0]               scan_pick;
    logic [pst_pkg::PRIO_W-1:0]  scan_best;

    // slot table
    pst_table #(.SLOTS(SLOTS)) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // pick accumulator
    pst_scan #(.SLOTS(SLOTS)) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (scan_clear),
        .en          (scan_en),
        .create_mode (scan_create),
        .idx         (scan_idx),
        .entry       (rd_data),
        .flags       (scan_flags),
        .pick        (scan_pick),
        .best        (scan_best)
    );

    // sequencer
    pst_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .scan_clear  (scan_clear),
        .scan_en     (scan_en),
        .scan_create (scan_create),
        .scan_idx    (scan_idx),
        .scan_flags  (scan_flags),
        .scan_pick   (scan_pick),
        .scan_best   (scan_best)
    );

endmodule
